// ----- src/shadow_silhouette_edge_extruder_defines.svh -----
// Assertion macros for the shadow silhouette edge extruder.
`ifndef SHADOW_SILHOUETTE_EDGE_EXTRUDER_DEFINES_SVH
`define SHADOW_SILHOUETTE_EDGE_EXTRUDER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SSEE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("ssee assertion failed");

// next-cycle implication, disabled in reset
`define SSEE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("ssee assertion failed");

`endif

// ----- src/ssee_pkg.sv -----
// Shared constants and types for the shadow silhouette edge extruder.
package ssee_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int LIGHT_W = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_Z = 2'd2;

	localparam logic signed [LIGHT_W-1:0] LIGHT_X_RST = 16'sd0;
	localparam logic signed [LIGHT_W-1:0] LIGHT_Y_RST = 16'sd0;
	localparam logic signed [LIGHT_W-1:0] LIGHT_Z_RST = 16'sd16384;

	// per-stage load enables of the facing pipeline
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} ld_t;

endpackage

// ----- src/ssee_facing.sv -----
// Facing value pipeline: sign of (e x u) . light over stages s2 to s6.
module ssee_facing import ssee_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                              clk,
	input  ld_t                               ld,
	input  logic signed [COORD_BITS:0]        e_x,
	input  logic signed [COORD_BITS:0]        e_y,
	input  logic signed [COORD_BITS:0]        e_z,
	input  logic signed [COORD_BITS:0]        u_x,
	input  logic signed [COORD_BITS:0]        u_y,
	input  logic signed [COORD_BITS:0]        u_z,
	input  logic signed [LIGHT_W-1:0]         light_x,
	input  logic signed [LIGHT_W-1:0]         light_y,
	input  logic signed [LIGHT_W-1:0]         light_z,
	output logic                              neg,
	output logic                              nz
);

	localparam int DW  = COORD_BITS + 1;
	localparam int PW  = 2 * DW;
	localparam int NW  = PW + 1;
	localparam int K   = DW + 1;
	localparam int HW  = NW - K;
	localparam int HPW = HW + LIGHT_W;
	localparam int LPW = K + 1 + LIGHT_W;
	localparam int SHW = HPW + 2;
	localparam int SLW = LPW + 2;
	localparam int SW  = SHW + K + 1;

	logic signed [LIGHT_W-1:0] lt [3];
	logic signed [PW-1:0]  pa_s2 [3];
	logic signed [PW-1:0]  pb_s2 [3];
	logic signed [NW-1:0]  n_s3 [3];
	logic signed [HPW-1:0] ph_s4 [3];
	logic signed [LPW-1:0] pl_s4 [3];
	logic signed [SHW-1:0] sh_s5;
	logic signed [SLW-1:0] sl_s5;
	logic signed [SW-1:0]  total;
	logic                  neg_s6;
	logic                  nz_s6;

	assign lt[0] = light_x;
	assign lt[1] = light_y;
	assign lt[2] = light_z;

	// cross product terms
	always_ff @(posedge clk) begin
		if (ld.s2) begin
			pa_s2[0] <= e_y * u_z;
			pb_s2[0] <= e_z * u_y;
			pa_s2[1] <= e_z * u_x;
			pb_s2[1] <= e_x * u_z;
			pa_s2[2] <= e_x * u_y;
			pb_s2[2] <= e_y * u_x;
		end
	end

	always_ff @(posedge clk) begin
		if (ld.s3) begin
			for (int i = 0; i < 3; i++)
				n_s3[i] <= NW'(pa_s2[i]) - NW'(pb_s2[i]);
		end
	end

	// normal split into signed high and unsigned low halves, each times light
	always_ff @(posedge clk) begin
		if (ld.s4) begin
			for (int i = 0; i < 3; i++) begin
				ph_s4[i] <= $signed(n_s3[i][NW-1:K]) * lt[i];
				pl_s4[i] <= $signed({1'b0, n_s3[i][K-1:0]}) * lt[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld.s5) begin
			sh_s5 <= SHW'(ph_s4[0]) + SHW'(ph_s4[1]) + SHW'(ph_s4[2]);
			sl_s5 <= SLW'(pl_s4[0]) + SLW'(pl_s4[1]) + SLW'(pl_s4[2]);
		end
	end

	assign total = (SW'(sh_s5) <<< K) + SW'(sl_s5);

	always_ff @(posedge clk) begin
		if (ld.s6) begin
			neg_s6 <= total[SW-1];
			nz_s6  <= |total;
		end
	end

	assign neg = neg_s6;
	assign nz  = nz_s6;

endmodule

// ----- src/shadow_silhouette_edge_extruder.sv -----
// An edge passes stages s1 to s6 into the quad emitter; its first vertex is then valid.
// Throughput: one edge per cycle while edges are not silhouettes; a silhouette edge
// occupies the single vertex output for four vertices while the next silhouette waits in s6.
// The 6-stage pipeline s1 to s6 stalls stage by stage behind a busy emitter; nothing is lost.
// Reset (arst_n low, asynchronous): pipeline and emitter empty, light = (0, 0, 16384).
module shadow_silhouette_edge_extruder import ssee_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, d_x, d_y, d_z
	input  logic [((12*COORD_BITS+7)/8)*8-1:0]     s_tdata,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// pos_x, pos_y, pos_z
	output logic [((3*COORD_BITS+7)/8)*8-1:0]      m_tdata,
	// extruded
	output logic                                   m_tuser,
	output logic                                   m_tlast,
	input  logic                                   cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]                   cfg_index,
	input  logic [LIGHT_W-1:0]                     cfg_wdata
);

	`include "shadow_silhouette_edge_extruder_defines.svh"

	localparam int CB    = COORD_BITS;
	localparam int DW    = CB + 1;
	localparam int OUT_W = ((3*CB+7)/8)*8;
	localparam int AB_W  = 6 * CB;

	logic signed [LIGHT_W-1:0] light_x_q, light_y_q, light_z_q;

	logic signed [CB-1:0] in_a [3];
	logic signed [CB-1:0] in_b [3];
	logic signed [CB-1:0] in_c [3];
	logic signed [CB-1:0] in_d [3];

	logic signed [DW-1:0] e_s1 [3];
	logic signed [DW-1:0] u1_s1 [3];
	logic signed [DW-1:0] u2_s1 [3];
	logic [AB_W-1:0] ab_s1, ab_s2, ab_s3, ab_s4, ab_s5, ab_s6;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	logic ld1;
	ld_t  ld;
	logic neg1, nz1, neg2, nz2;
	logic silh, pass6, emit_free;

	logic [3*CB-1:0] ea_q, eb_q, pos;
	logic            f1_q, f2_q, ev_q;
	logic [1:0]      cnt_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_x_q <= LIGHT_X_RST;
			light_y_q <= LIGHT_Y_RST;
			light_z_q <= LIGHT_Z_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_LIGHT_X: light_x_q <= cfg_wdata;
				CFG_LIGHT_Y: light_y_q <= cfg_wdata;
				CFG_LIGHT_Z: light_z_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// stall chain: a stage loads when empty or when its word moves on
	assign silh      = (neg1 != neg2) && nz1 && nz2;
	assign emit_free = !ev_q || (m_tready && cnt_q == 2'd3);
	assign pass6     = !silh || emit_free;
	assign ld.s6     = !v_s6 || pass6;
	assign ld.s5     = !v_s5 || ld.s6;
	assign ld.s4     = !v_s4 || ld.s5;
	assign ld.s3     = !v_s3 || ld.s4;
	assign ld.s2     = !v_s2 || ld.s3;
	assign ld1       = !v_s1 || ld.s2;
	assign s_tready  = ld1;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			in_a[i] = s_tdata[i*CB +: CB];
			in_b[i] = s_tdata[(3+i)*CB +: CB];
			in_c[i] = s_tdata[(6+i)*CB +: CB];
			in_d[i] = s_tdata[(9+i)*CB +: CB];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (ld1)   v_s1 <= s_tvalid;
			if (ld.s2) v_s2 <= v_s1;
			if (ld.s3) v_s3 <= v_s2;
			if (ld.s4) v_s4 <= v_s3;
			if (ld.s5) v_s5 <= v_s4;
			if (ld.s6) v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (ld1) begin
			ab_s1 <= s_tdata[AB_W-1:0];
			for (int i = 0; i < 3; i++) begin
				e_s1[i]  <= DW'(in_b[i]) - DW'(in_a[i]);
				u1_s1[i] <= DW'(in_c[i]) - DW'(in_a[i]);
				u2_s1[i] <= DW'(in_a[i]) - DW'(in_d[i]);
			end
		end
		if (ld.s2) ab_s2 <= ab_s1;
		if (ld.s3) ab_s3 <= ab_s2;
		if (ld.s4) ab_s4 <= ab_s3;
		if (ld.s5) ab_s5 <= ab_s4;
		if (ld.s6) ab_s6 <= ab_s5;
	end

	ssee_facing #(.COORD_BITS(CB)) u_face1 (
		.clk     (clk),
		.ld      (ld),
		.e_x     (e_s1[0]),
		.e_y     (e_s1[1]),
		.e_z     (e_s1[2]),
		.u_x     (u1_s1[0]),
		.u_y     (u1_s1[1]),
		.u_z     (u1_s1[2]),
		.light_x (light_x_q),
		.light_y (light_y_q),
		.light_z (light_z_q),
		.neg     (neg1),
		.nz      (nz1)
	);

	ssee_facing #(.COORD_BITS(CB)) u_face2 (
		.clk     (clk),
		.ld      (ld),
		.e_x     (e_s1[0]),
		.e_y     (e_s1[1]),
		.e_z     (e_s1[2]),
		.u_x     (u2_s1[0]),
		.u_y     (u2_s1[1]),
		.u_z     (u2_s1[2]),
		.light_x (light_x_q),
		.light_y (light_y_q),
		.light_z (light_z_q),
		.neg     (neg2),
		.nz      (nz2)
	);

	// quad emitter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else if (emit_free) begin
			ev_q  <= v_s6 && silh;
			cnt_q <= 2'd0;
		end else if (m_tready) begin
			cnt_q <= cnt_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_free && v_s6 && silh) begin
			ea_q <= ab_s6[3*CB-1:0];
			eb_q <= ab_s6[AB_W-1:3*CB];
			f1_q <= neg1;
			f2_q <= neg2;
		end
	end

	assign pos      = cnt_q[1] ? eb_q : ea_q;
	assign m_tvalid = ev_q;
	assign m_tdata  = OUT_W'(pos);
	assign m_tuser  = (cnt_q[0] ^ cnt_q[1]) ? f2_q : f1_q;
	assign m_tlast  = (cnt_q == 2'd3);

	`SSEE_ASSERT_NXT(a_cnt_step, clk, arst_n, ev_q && m_tready && cnt_q != 2'd3, ev_q && cnt_q == $past(cnt_q) + 2'd1)
	`SSEE_ASSERT_NXT(a_flag_flip, clk, arst_n, ev_q && m_tready && cnt_q == 2'd0, m_tuser != $past(m_tuser))
	`SSEE_ASSERT_NXT(a_s6_hold, clk, arst_n, v_s6 && silh && !emit_free, v_s6 && $stable(ab_s6))

endmodule
